// ===== hw/rtl/bra_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the bitmap range allocator.
// Used by the controller, the datapath, the top level and the checker; no dependencies.

package bra_pkg;

  // Map geometry.
  localparam int unsigned MAP_BITS    = 1024;
  localparam int unsigned WORD_BITS   = 64;
  localparam int unsigned MAP_WORDS   = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WORD_AW     = $clog2(MAP_WORDS);
  localparam int unsigned BIT_AW      = $clog2(WORD_BITS);

  // Searches walk the map one chunk at a time.
  localparam int unsigned CHUNK_BITS  = 8;
  localparam int unsigned CHUNK_OFF_W = $clog2(CHUNK_BITS);
  localparam int unsigned CHUNK_SEL_W = $clog2(WORD_BITS / CHUNK_BITS);
  localparam int unsigned CHUNK_AW    = WORD_AW + CHUNK_SEL_W;
  localparam int unsigned CHUNKS      = MAP_WORDS * (WORD_BITS / CHUNK_BITS);

  // Field widths.
  localparam int unsigned POS_W = 10;
  localparam int unsigned LEN_W = 11;

  localparam logic [LEN_W-1:0] MAP_BITS_L     = LEN_W'(MAP_BITS);
  localparam logic [LEN_W-1:0] MAP_SIZE_RESET = LEN_W'(1024);

  typedef enum logic [1:0] {
    CMD_MARK_USED = 2'd0,
    CMD_MARK_FREE = 2'd1,
    CMD_FIND_FREE = 2'd2,
    CMD_FIND_USED = 2'd3
  } command_e;

  typedef struct packed {
    command_e               command;
    logic [POS_W-1:0]       start_position;
    logic [LEN_W-1:0]       run_length;
  } alloc_req_t;

  typedef struct packed {
    logic                   found;
    logic [POS_W-1:0]       run_start;
    logic [LEN_W-1:0]       run_bits;
  } alloc_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_REPLY = 2'd2
  } ctrl_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic last;
    logic out_free;
  } dp_status_t;

endpackage

// ===== hw/rtl/bra_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencing state machine for the bitmap range allocator.
// Depends on bra_pkg for the state, command and status types.

module bra_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  bra_pkg::dp_status_t    status_i,
  output bra_pkg::ctrl_cmd_t     cmd_o
);

  bra_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bra_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      bra_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = bra_pkg::ST_SCAN;
        end
      end
      bra_pkg::ST_SCAN: begin
        cmd_o.step = 1'b1;
        if (status_i.last) begin
          state_d = bra_pkg::ST_REPLY;
        end
      end
      bra_pkg::ST_REPLY: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = bra_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bra_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/bra_dpath.sv =====
`timescale 1ns / 1ps
// Datapath of the bitmap range allocator: bitmap words, scan registers and result register.
// Depends on bra_pkg; driven by bra_ctrl through ctrl_cmd_t.

module bra_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bra_pkg::ctrl_cmd_t            cmd_i,
  output bra_pkg::dp_status_t           status_o,
  input  bra_pkg::alloc_req_t           in_req_i,
  input  logic                          cfg_valid_i,
  input  logic [bra_pkg::LEN_W-1:0]     cfg_data_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output bra_pkg::alloc_rsp_t           out_rsp_o
);

  localparam int unsigned OFF_W = bra_pkg::BIT_AW + 1;

  logic [bra_pkg::WORD_BITS-1:0] bitmap_q [bra_pkg::MAP_WORDS];
  logic [bra_pkg::LEN_W-1:0]     map_size_q;

  bra_pkg::command_e             op_q;
  logic [bra_pkg::POS_W-1:0]     pos_q;
  logic [bra_pkg::LEN_W-1:0]     len_q;
  logic [bra_pkg::LEN_W-1:0]     end_q;
  logic [bra_pkg::CHUNK_AW-1:0]  scan_q;
  logic                          hit_q, hit_d;
  logic [bra_pkg::LEN_W-1:0]     run_q, run_d;
  logic [bra_pkg::POS_W-1:0]     at_q, at_d;
  logic                          out_valid_q;
  bra_pkg::alloc_rsp_t           out_q, out_d;

  logic [bra_pkg::LEN_W-1:0]     sz;
  logic                          is_mark;
  logic [bra_pkg::WORD_AW-1:0]   rd_word;
  logic [bra_pkg::WORD_BITS-1:0] cur_word;
  logic [bra_pkg::CHUNK_BITS-1:0] chunk;
  logic [bra_pkg::LEN_W-1:0]     chunk_base;
  logic [bra_pkg::LEN_W-1:0]     chunk_end;
  logic                          scan_final;
  logic [bra_pkg::CHUNK_BITS-1:0] in_win;
  logic [bra_pkg::CHUNK_BITS-1:0] past_pos;

  // Free-run search step.
  logic                          f_hit;
  logic [bra_pkg::LEN_W-1:0]     f_zeros;
  logic [bra_pkg::POS_W-1:0]     f_at;

  // Used-run search step.
  logic                          u_hit;
  logic                          u_done;
  logic [bra_pkg::LEN_W-1:0]     u_run;
  logic [bra_pkg::POS_W-1:0]     u_at;

  // Mark step.
  logic [bra_pkg::LEN_W-1:0]     lo;
  logic [bra_pkg::LEN_W-1:0]     lo_top;
  logic [OFF_W-1:0]              s_off;
  logic [OFF_W-1:0]              e_off;
  logic [bra_pkg::WORD_BITS-1:0] mask;
  logic                          mark_last;

  logic [bra_pkg::LEN_W:0]       req_end;

  assign sz = (map_size_q < bra_pkg::MAP_BITS_L) ? map_size_q : bra_pkg::MAP_BITS_L;
  assign is_mark = (op_q == bra_pkg::CMD_MARK_USED) || (op_q == bra_pkg::CMD_MARK_FREE);

  // One read port on the word array, shared by marks and searches.
  assign rd_word  = is_mark ? scan_q[bra_pkg::WORD_AW-1:0]
                            : scan_q[bra_pkg::CHUNK_AW-1:bra_pkg::CHUNK_SEL_W];
  assign cur_word = bitmap_q[rd_word];
  assign chunk    = cur_word[{scan_q[bra_pkg::CHUNK_SEL_W-1:0],
                              bra_pkg::CHUNK_OFF_W'(0)} +: bra_pkg::CHUNK_BITS];

  assign chunk_base = bra_pkg::LEN_W'({scan_q, bra_pkg::CHUNK_OFF_W'(0)});
  assign chunk_end  = chunk_base + bra_pkg::LEN_W'(bra_pkg::CHUNK_BITS);
  assign scan_final = (scan_q == bra_pkg::CHUNK_AW'(bra_pkg::CHUNKS - 1));

  always_comb begin
    for (int j = 0; j < bra_pkg::CHUNK_BITS; j++) begin
      in_win[j]   = (chunk_base + bra_pkg::LEN_W'(j)) < sz;
      past_pos[j] = (chunk_base + bra_pkg::LEN_W'(j)) >= bra_pkg::LEN_W'(pos_q);
    end
  end

  // First fit: count consecutive free bits, stop when the count reaches the request.
  always_comb begin
    f_hit   = hit_q;
    f_zeros = run_q;
    f_at    = at_q;
    for (int j = 0; j < bra_pkg::CHUNK_BITS; j++) begin
      if (!f_hit && in_win[j]) begin
        if (chunk[j]) begin
          f_zeros = '0;
        end else begin
          f_zeros = f_zeros + bra_pkg::LEN_W'(1);
          if (f_zeros == len_q) begin
            f_hit = 1'b1;
            f_at  = bra_pkg::POS_W'(chunk_base + bra_pkg::LEN_W'(j)
                                    + bra_pkg::LEN_W'(1) - len_q);
          end
        end
      end
    end
  end

  // Used run: seek the first set bit at or after the start, then count set bits.
  always_comb begin
    u_hit  = hit_q;
    u_run  = run_q;
    u_at   = at_q;
    u_done = 1'b0;
    for (int j = 0; j < bra_pkg::CHUNK_BITS; j++) begin
      if (!u_done) begin
        if (!u_hit) begin
          if (in_win[j] && past_pos[j] && chunk[j]) begin
            u_hit = 1'b1;
            u_at  = bra_pkg::POS_W'(chunk_base + bra_pkg::LEN_W'(j));
            u_run = bra_pkg::LEN_W'(1);
          end
        end else if (in_win[j] && chunk[j]) begin
          u_run = u_run + bra_pkg::LEN_W'(1);
        end else begin
          u_done = 1'b1;
        end
      end
    end
  end

  // Mark: build the mask of the range bits that fall in the current word.
  assign lo     = bra_pkg::LEN_W'({scan_q[bra_pkg::WORD_AW-1:0], bra_pkg::BIT_AW'(0)});
  assign lo_top = lo + bra_pkg::LEN_W'(bra_pkg::WORD_BITS);
  assign s_off  = (bra_pkg::LEN_W'(pos_q) > lo) ? OFF_W'(bra_pkg::LEN_W'(pos_q) - lo) : '0;
  assign e_off  = (end_q >= lo_top) ? OFF_W'(bra_pkg::WORD_BITS) :
                  (end_q <= lo)     ? '0 : OFF_W'(end_q - lo);
  assign mark_last = (lo_top >= end_q);

  always_comb begin
    for (int b = 0; b < bra_pkg::WORD_BITS; b++) begin
      mask[b] = (OFF_W'(b) >= s_off) && (OFF_W'(b) < e_off);
    end
  end

  // Step results, completion and output register space.
  always_comb begin
    hit_d             = hit_q;
    run_d             = run_q;
    at_d              = at_q;
    status_o.last     = 1'b1;
    status_o.out_free = !out_valid_q || out_ready_i;
    unique case (op_q)
      bra_pkg::CMD_MARK_USED, bra_pkg::CMD_MARK_FREE: begin
        status_o.last = mark_last;
      end
      bra_pkg::CMD_FIND_FREE: begin
        hit_d         = f_hit;
        run_d         = f_zeros;
        at_d          = f_at;
        status_o.last = f_hit || (chunk_end >= sz) || scan_final;
      end
      bra_pkg::CMD_FIND_USED: begin
        hit_d         = u_hit;
        run_d         = u_run;
        at_d          = u_at;
        status_o.last = u_done || (chunk_end >= sz) || scan_final;
      end
      default: begin
        status_o.last = 1'b1;
      end
    endcase
  end

  // Result formatting.
  always_comb begin
    out_d = '0;
    unique case (op_q)
      bra_pkg::CMD_MARK_USED, bra_pkg::CMD_MARK_FREE: begin
        out_d.found = 1'b1;
      end
      bra_pkg::CMD_FIND_FREE: begin
        if (hit_q) begin
          out_d.found     = 1'b1;
          out_d.run_start = at_q;
          out_d.run_bits  = len_q;
        end
      end
      bra_pkg::CMD_FIND_USED: begin
        if (hit_q) begin
          out_d.found     = 1'b1;
          out_d.run_start = at_q;
          out_d.run_bits  = run_q;
        end
      end
      default: begin
        out_d = '0;
      end
    endcase
  end

  assign req_end = {1'b0, bra_pkg::LEN_W'(in_req_i.start_position)}
                 + {1'b0, in_req_i.run_length};

  // Bitmap words and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < bra_pkg::MAP_WORDS; w++) begin
        bitmap_q[w] <= '0;
      end
      map_size_q <= bra_pkg::MAP_SIZE_RESET;
    end else begin
      if (cmd_i.step && is_mark) begin
        if (op_q == bra_pkg::CMD_MARK_USED) begin
          bitmap_q[rd_word] <= cur_word | mask;
        end else begin
          bitmap_q[rd_word] <= cur_word & ~mask;
        end
      end
      if (cfg_valid_i) begin
        map_size_q <= cfg_data_i;
      end
    end
  end

  // Request and scan registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= in_req_i.command;
      pos_q <= in_req_i.start_position;
      len_q <= in_req_i.run_length;
      end_q <= (req_end > {1'b0, bra_pkg::MAP_BITS_L}) ? bra_pkg::MAP_BITS_L
                                                         : req_end[bra_pkg::LEN_W-1:0];
      hit_q <= 1'b0;
      run_q <= '0;
      at_q  <= '0;
      unique case (in_req_i.command)
        bra_pkg::CMD_MARK_USED, bra_pkg::CMD_MARK_FREE: begin
          scan_q <= bra_pkg::CHUNK_AW'(in_req_i.start_position >> bra_pkg::BIT_AW);
        end
        bra_pkg::CMD_FIND_FREE: begin
          scan_q <= '0;
        end
        bra_pkg::CMD_FIND_USED: begin
          scan_q <= bra_pkg::CHUNK_AW'(in_req_i.start_position >> bra_pkg::CHUNK_OFF_W);
        end
        default: begin
          scan_q <= '0;
        end
      endcase
    end else if (cmd_i.step) begin
      scan_q <= scan_q + bra_pkg::CHUNK_AW'(1);
      hit_q  <= hit_d;
      run_q  <= run_d;
      at_q   <= at_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

// ===== hw/rtl/bitmap_range_allocator.sv =====
`timescale 1ns / 1ps
// Top level of the bitmap range allocator: controller plus datapath.
// Depends on bra_pkg, bra_ctrl and bra_dpath.
//
// The block keeps a 1024-bit allocation bitmap, all free after reset, and serves one
// request at a time on the input channel (in_valid_i / in_ready_o, payload in_req_i).
// A request marks a range used, marks a range free, searches first fit for a free run
// of the requested length, or finds the next used run at or after a position.
// Every request returns exactly one response on the output channel (out_valid_o /
// out_ready_i, payload out_rsp_o), in request order.
// Sequence: the request is taken in the idle state, then the scan runs, then the reply
// state loads the output register once it has room. Marks walk one 64-bit word per cycle
// over the words the range touches. Searches walk 8 bits per cycle through the shared
// bitmap read port: a free-run search starts at bit 0 and stops at the first fit or at
// the search size, a used-run search starts at the chunk holding the start position and
// stops at the end of the run or at the search size, whichever comes first.
// The output register decouples the sides: a new request is taken while the previous
// response still waits; if the receiver stalls, the next response waits in the block
// and no further request is taken until it is loaded.
// The map_size register (cfg_valid_i / cfg_ready_o / cfg_data_i, always ready) limits
// searches; write it only while the block is idle. Reset (rst_ni, asynchronous, active
// low) clears the bitmap, sets map_size to 1024 and empties the output register.

module bitmap_range_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  bra_pkg::alloc_req_t           in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output bra_pkg::alloc_rsp_t           out_rsp_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bra_pkg::LEN_W-1:0]     cfg_data_i
);

  bra_pkg::ctrl_cmd_t  ctrl_cmd;
  bra_pkg::dp_status_t dp_status;

  // The configuration register is a plain flop, so writes are always taken.
  assign cfg_ready_o = 1'b1;

  bra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (dp_status),
    .cmd_o      (ctrl_cmd)
  );

  bra_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ctrl_cmd),
    .status_o    (dp_status),
    .in_req_i    (in_req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

// ===== hw/rtl/bra_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the bitmap range allocator, bound to the top level.
// Depends on bra_pkg and bitmap_range_allocator.

module bra_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input bra_pkg::alloc_rsp_t  out_rsp_o
);

  // A stalled response holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled response changed");

  // One request at a time: after a request is taken the block is busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while previous one in progress");

  // A failed search reports zeros.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.found |-> out_rsp_o.run_start == '0 && out_rsp_o.run_bits == '0)
    else $error("not-found response carries a position");

  // A zero-length success is a mark response and starts at zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.found && out_rsp_o.run_bits == '0 |-> out_rsp_o.run_start == '0)
    else $error("mark response with nonzero start");

  // A run found lies inside the map.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.found |->
      ({1'b0, bra_pkg::LEN_W'(out_rsp_o.run_start)} + {1'b0, out_rsp_o.run_bits})
        <= {1'b0, bra_pkg::MAP_BITS_L})
    else $error("run extends beyond the map");

endmodule

bind bitmap_range_allocator bra_checker u_bra_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);

// ===== dv/bitmap_range_allocator_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for bitmap_range_allocator: directed, map_size sweep, random
// allocate/release traffic and a long output stall. Depends on bra_pkg and the RTL only.

module bitmap_range_allocator_tb;

  // Enough for a used-run search over all 128 chunks, plus the request and reply states.
  localparam int unsigned SCAN_LATENCY = 140;
  // Cycles to wait before a map_size write once all replies have come back.
  localparam int unsigned SETTLE_CYCLES = 4;
  // Length of the deliberate receiver hold-off, in clock cycles.
  localparam int unsigned HOLD_CYCLES = 300;
  // Cycles without any handshake before the run is declared hung. The slowest
  // legal gap is the hold-off plus a couple of full scans.
  localparam int unsigned QUIET_LIMIT = 4000;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  bra_pkg::alloc_req_t       in_req_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  bra_pkg::alloc_rsp_t       out_rsp_o;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [bra_pkg::LEN_W-1:0] cfg_data_i;

  bitmap_range_allocator uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // Shadow copy of the allocation bitmap and the map_size register. Bit i lives in
  // word i / WORD_BITS at position i % WORD_BITS, exactly as in the block.
  logic [bra_pkg::WORD_BITS-1:0] shadow_map [bra_pkg::MAP_WORDS];
  logic [bra_pkg::LEN_W-1:0]     shadow_map_size;

  // Replies the block owes us, oldest first.
  bra_pkg::alloc_rsp_t alloc_replies_due [$];

  int unsigned requests_sent;
  int unsigned replies_checked;
  int unsigned map_size_writes;
  int unsigned mismatches;
  int unsigned quiet_cycles;

  // When set, neither side inserts idle cycles.
  bit no_idle;
  // The stimulus bumps hold_requests to ask for a hold-off; the receiver process
  // tracks how many it has served and counts the stall itself.
  int unsigned hold_requests;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Reads one bit of the shadow bitmap.
  function automatic bit map_bit(int unsigned idx);
    return shadow_map[idx / bra_pkg::WORD_BITS][idx % bra_pkg::WORD_BITS];
  endfunction

  // Applies one request to the shadow bitmap and works out the reply the block must
  // give. Marks are bounded by the map capacity only, searches by the search size,
  // which is map_size clipped to the capacity.
  task automatic apply_bitmap_cmd(input bra_pkg::alloc_req_t req,
                                  output bra_pkg::alloc_rsp_t rsp);
    int unsigned limit;
    int unsigned pos;
    int unsigned len;
    int unsigned zeros;
    int unsigned p0;
    int unsigned p1;
    int unsigned i;
    rsp   = '0;
    limit = (shadow_map_size < bra_pkg::MAP_BITS) ? shadow_map_size : bra_pkg::MAP_BITS;
    pos   = req.start_position;
    len   = req.run_length;
    case (req.command)
      bra_pkg::CMD_MARK_USED, bra_pkg::CMD_MARK_FREE: begin
        // Bits at or above the capacity are dropped; the rest of the range is marked.
        for (i = pos; i < pos + len && i < bra_pkg::MAP_BITS; i++) begin
          shadow_map[i / bra_pkg::WORD_BITS][i % bra_pkg::WORD_BITS] =
            (req.command == bra_pkg::CMD_MARK_USED);
        end
        rsp.found = 1'b1;
      end
      bra_pkg::CMD_FIND_FREE: begin
        // First fit; a zero-length request never succeeds.
        zeros = 0;
        if (len != 0) begin
          for (i = 0; i < limit; i++) begin
            if (map_bit(i)) begin
              zeros = 0;
            end else begin
              zeros++;
              if (zeros == len) begin
                rsp.found     = 1'b1;
                rsp.run_start = bra_pkg::POS_W'(i + 1 - len);
                rsp.run_bits  = bra_pkg::LEN_W'(len);
                break;
              end
            end
          end
        end
      end
      bra_pkg::CMD_FIND_USED: begin
        // Skip free bits from the start position, then measure the used run; the run
        // is cut off at the search size.
        p0 = pos;
        while (p0 < limit && !map_bit(p0)) p0++;
        if (p0 < limit) begin
          p1 = p0;
          while (p1 < limit && map_bit(p1)) p1++;
          rsp.found     = 1'b1;
          rsp.run_start = bra_pkg::POS_W'(p0);
          rsp.run_bits  = bra_pkg::LEN_W'(p1 - p0);
        end
      end
      default: begin
      end
    endcase
  endtask

  function automatic bra_pkg::alloc_req_t make_req(bra_pkg::command_e cmd, int unsigned pos,
                                                   int unsigned len);
    bra_pkg::alloc_req_t req;
    req.command        = cmd;
    req.start_position = bra_pkg::POS_W'(pos);
    req.run_length     = bra_pkg::LEN_W'(len);
    return req;
  endfunction

  // Lengths lean toward small runs, with the occasional huge or zero length.
  function automatic logic [bra_pkg::LEN_W-1:0] pick_length();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 3) return '0;
    if (roll < 70) return bra_pkg::LEN_W'($urandom_range(16, 1));
    if (roll < 90) return bra_pkg::LEN_W'($urandom_range(128, 17));
    if (roll < 97) return bra_pkg::LEN_W'($urandom_range(1024, 129));
    return bra_pkg::LEN_W'($urandom_range(2047, 1025));
  endfunction

  // Offers one request, waits for it to be taken and records the reply it owes.
  // Valid stays high after acceptance so that back-to-back requests need no gap;
  // the next call or settle_block decides what happens at the following falling edge.
  task automatic send_request(input bra_pkg::alloc_req_t req,
                              output bra_pkg::alloc_rsp_t rsp);
    while (!no_idle && $urandom_range(99) < 28) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (!in_ready_o);
    apply_bitmap_cmd(req, rsp);
    alloc_replies_due.push_back(rsp);
    requests_sent++;
  endtask

  // Drops the request line, waits for every owed reply and lets the block go quiet.
  task automatic settle_block(input int unsigned extra_cycles);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (alloc_replies_due.size() != 0) @(posedge clk_i);
    repeat (extra_cycles) @(posedge clk_i);
  endtask

  // Writes map_size with the block idle.
  task automatic write_map_size(input logic [bra_pkg::LEN_W-1:0] value);
    settle_block(SETTLE_CYCLES);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow_map_size = value;
    map_size_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Edge cases on an empty and then a full map: zero lengths, ranges running past the
  // end of the map, runs crossing a word boundary, searches that just fit or just miss.
  task automatic test_directed();
    bra_pkg::alloc_req_t reqs [$];
    bra_pkg::alloc_rsp_t rsp;
    reqs.push_back(make_req(bra_pkg::CMD_FIND_FREE, 0, 1));
    reqs.push_back(make_req(bra_pkg::CMD_FIND_USED, 0, 0));
    reqs.push_back(make_req(bra_pkg::CMD_FIND_FREE, 0, 0));
    reqs.push_back(make_req(bra_pkg::CMD_FIND_FREE, 0, 1024));
    reqs.push_back(make_req(bra_pkg::CMD_FIND_FREE, 0, 2047));
    reqs.push_back(make_req(bra_pkg::CMD_MARK_USED, 5, 0));
    reqs.push_back(make_req(bra_pkg::CMD_MARK_USED, 1020, 2047));
    reqs.push_back(make_req(bra_pkg::CMD_FIND_USED, 0, 0));
    reqs.push_back(make_req(bra_pkg::CMD_FIND_USED, 1023, 0));
    reqs.push_back(make_req(bra_pkg::CMD_MARK_USED, 0, 1024));
    reqs.push_back(make_req(bra_pkg::CMD_FIND_FREE, 0, 1));
    reqs.push_back(make_req(bra_pkg::CMD_FIND_USED, 341, 0));
    reqs.push_back(make_req(bra_pkg::CMD_MARK_FREE, 64, 64));
    reqs.push_back(make_req(bra_pkg::CMD_FIND_FREE, 0, 64));
    reqs.push_back(make_req(bra_pkg::CMD_FIND_FREE, 0, 65));
    reqs.push_back(make_req(bra_pkg::CMD_MARK_FREE, 682, 341));
    reqs.push_back(make_req(bra_pkg::CMD_FIND_FREE, 1023, 300));
    reqs.push_back(make_req(bra_pkg::CMD_MARK_FREE, 0, 2047));
    reqs.push_back(make_req(bra_pkg::CMD_MARK_USED, 63, 2));
    reqs.push_back(make_req(bra_pkg::CMD_FIND_USED, 0, 0));
    reqs.push_back(make_req(bra_pkg::CMD_FIND_FREE, 0, 100));
    reqs.push_back(make_req(bra_pkg::CMD_MARK_FREE, 0, 1024));
    foreach (reqs[k]) send_request(reqs[k], rsp);
  endtask

  // Sweeps map_size over its extremes with two used runs in place, one of them beyond
  // most search sizes, and probes searches at and around the limit.
  task automatic test_map_size();
    int unsigned         sizes [5];
    bra_pkg::alloc_rsp_t rsp;
    int unsigned         edge_pos;
    sizes = '{0, 1, 65, 2047, 1024};
    send_request(make_req(bra_pkg::CMD_MARK_USED, 60, 10), rsp);
    send_request(make_req(bra_pkg::CMD_MARK_USED, 900, 50), rsp);
    foreach (sizes[k]) begin
      write_map_size(bra_pkg::LEN_W'(sizes[k]));
      edge_pos = (sizes[k] > 1023) ? 1023 : sizes[k];
      send_request(make_req(bra_pkg::CMD_FIND_FREE, 0, 1), rsp);
      send_request(make_req(bra_pkg::CMD_FIND_FREE, 0, 8), rsp);
      send_request(make_req(bra_pkg::CMD_FIND_USED, 0, 0), rsp);
      send_request(make_req(bra_pkg::CMD_FIND_USED, edge_pos, 0), rsp);
    end
    send_request(make_req(bra_pkg::CMD_MARK_FREE, 0, 2047), rsp);
  endtask

  // Allocator-style traffic: most requests are find-then-mark allocations and
  // find-then-free releases built from the predicted replies, the rest are arbitrary
  // requests over the full field ranges. Each phase runs under its own map_size, and
  // one phase runs with no idle cycles on either side.
  task automatic test_random();
    int unsigned         phase_size [6];
    int unsigned         phase_items [6];
    int unsigned         sent;
    int unsigned         roll;
    bra_pkg::alloc_req_t req;
    bra_pkg::alloc_rsp_t rsp;
    phase_size  = '{1024, 513, 2047, 64, 1000, 1024};
    phase_items = '{150, 100, 100, 60, 100, 90};
    foreach (phase_size[p]) begin
      write_map_size(bra_pkg::LEN_W'(phase_size[p]));
      no_idle = (p == 1);
      sent = 0;
      while (sent < phase_items[p]) begin
        roll = $urandom_range(99);
        if (roll < 35) begin
          req = make_req(bra_pkg::CMD_FIND_FREE, $urandom_range(1023), pick_length());
          send_request(req, rsp);
          sent++;
          if (rsp.found) begin
            send_request(make_req(bra_pkg::CMD_MARK_USED, rsp.run_start, rsp.run_bits),
                         rsp);
            sent++;
          end
        end else if (roll < 60) begin
          req = make_req(bra_pkg::CMD_FIND_USED, $urandom_range(1023),
                         $urandom_range(2047));
          send_request(req, rsp);
          sent++;
          if (rsp.found) begin
            // Release the whole run or just its head.
            req = make_req(bra_pkg::CMD_MARK_FREE, rsp.run_start,
                           $urandom_range(rsp.run_bits, 1));
            send_request(req, rsp);
            sent++;
          end
        end else begin
          req = make_req(bra_pkg::command_e'($urandom_range(3)), $urandom_range(1023),
                         pick_length());
          send_request(req, rsp);
          sent++;
        end
      end
    end
    no_idle = 1'b0;
  endtask

  // The receiver stops taking replies for a long stretch while requests keep coming,
  // so the output register and the pending reply fill up and the input stalls.
  task automatic test_backpressure();
    bra_pkg::alloc_rsp_t rsp;
    settle_block(SETTLE_CYCLES);
    hold_requests++;
    repeat (16) begin
      send_request(make_req(bra_pkg::command_e'($urandom_range(3)), $urandom_range(1023),
                            pick_length()), rsp);
    end
  endtask

  // Receiver: random ready with the same idle rate as the sender, except during a
  // requested hold-off, which this process counts down on its own.
  initial begin : receiver
    int unsigned holds_served;
    int unsigned hold_left;
    holds_served = 0;
    hold_left    = 0;
    out_ready_i  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= no_idle || ($urandom_range(99) >= 28);
      end
    end
  end

  // Reply checker: every reply taken is matched against the oldest one owed.
  always @(posedge clk_i) begin : reply_check
    bra_pkg::alloc_rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (alloc_replies_due.size() == 0) begin
        mismatches++;
        $display("%0t: reply with nothing owed: found=%0d start=%0d bits=%0d", $time,
                 out_rsp_o.found, out_rsp_o.run_start, out_rsp_o.run_bits);
      end else begin
        want = alloc_replies_due.pop_front();
        replies_checked++;
        if (out_rsp_o.found !== want.found) begin
          mismatches++;
          $display("%0t: found mismatch, expected %0d, got %0d", $time, want.found,
                   out_rsp_o.found);
        end
        if (out_rsp_o.run_start !== want.run_start) begin
          mismatches++;
          $display("%0t: run_start mismatch, expected %0d, got %0d", $time,
                   want.run_start, out_rsp_o.run_start);
        end
        if (out_rsp_o.run_bits !== want.run_bits) begin
          mismatches++;
          $display("%0t: run_bits mismatch, expected %0d, got %0d", $time,
                   want.run_bits, out_rsp_o.run_bits);
        end
      end
    end
  end

  // Watchdog: counts cycles in which no channel completes a handshake.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Hang: no handshake for %0d cycles, %0d replies still owed", QUIET_LIMIT,
             alloc_replies_due.size());
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    in_req_i        = '0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    no_idle         = 1'b0;
    hold_requests   = 0;
    requests_sent   = 0;
    replies_checked = 0;
    map_size_writes = 0;
    mismatches      = 0;
    quiet_cycles    = 0;
    // Reset state: every bit free, full search size.
    foreach (shadow_map[w]) shadow_map[w] = '0;
    shadow_map_size = bra_pkg::MAP_SIZE_RESET;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_map_size();
    test_random();
    test_backpressure();
    settle_block(SCAN_LATENCY);

    $display("Run covered %0d requests and %0d checked replies under %0d map_size writes,",
             requests_sent, replies_checked, map_size_writes);
    $display("with a %0d-cycle output stall and %0d field mismatches.", HOLD_CYCLES,
             mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
